### rtl/dtdq_pkg.sv
// Shared widths, limits and register indexes of the depth to disparity quantiser.
// No dependencies.
`timescale 1ns / 1ps

package dtdq_pkg;

   localparam int DEPTH_W     = 16;
   localparam int PROD_W      = 2 * DEPTH_W;
   localparam int NUM_W       = 3 * DEPTH_W;
   localparam int QUO_W       = DEPTH_W;
   localparam int DIV_STAGES  = QUO_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = DEPTH_W;

   localparam logic [DEPTH_W-1:0] DMAX_NARROW = 16'h00ff;
   localparam logic [DEPTH_W-1:0] DMAX_WIDE   = 16'hffff;

   localparam logic [DEPTH_W-1:0] NEAR_RESET = 16'h0000;
   localparam logic [DEPTH_W-1:0] FAR_RESET  = 16'hffff;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEAR_DEPTH  = 2'd0,
      CSR_FAR_DEPTH   = 2'd1,
      CSR_WIDE_OUTPUT = 2'd2
   } csr_index_type;

endpackage

### rtl/depth_to_disparity_quantizer.sv
// Depth to disparity quantiser: depth word in, rounded and saturated disparity word out.
// Depends on dtdq_pkg.
`timescale 1ns / 1ps

// Takes one depth word per clock while req_ready is high and returns one disparity word per depth word, in order.
// From accept to rsp_valid a word passes the entry stage, the two multipliers, the dmax scaling,
// the saturation compare, sixteen restoring-division stages (one quotient bit each), the
// rounding stage and the output register. The whole pipeline advances together, so a
// stalled rsp_ready holds every stage and req_ready drops while the output word waits.
// near_depth, far_depth and wide_output are sampled as each word enters.
module depth_to_disparity_quantizer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dtdq_pkg::DEPTH_W-1:0]        req_depth_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dtdq_pkg::DEPTH_W-1:0]        rsp_disparity,
   input  logic                                csr_wr_en,
   input  logic [dtdq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dtdq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import dtdq_pkg::*;

   logic                 adv;

   logic [DEPTH_W-1:0]   near_ff, near_in;
   logic [DEPTH_W-1:0]   far_ff, far_in;
   logic                 wide_ff, wide_in;

   // entry stage
   logic                 a_valid_ff;
   logic                 a_zero_ff, a_zero_in;
   logic                 a_wide_ff;
   logic [DEPTH_W-1:0]   a_zn_ff, a_z_ff;
   logic [DEPTH_W-1:0]   a_dz_ff, a_dz_in;
   logic [DEPTH_W-1:0]   a_dd_ff, a_dd_in;
   logic                 neg_num, neg_den;

   // multiplier stage
   logic                 b_valid_ff, b_zero_ff, b_wide_ff;
   logic [PROD_W-1:0]    b_prod_ff, b_prod_in;
   logic [PROD_W-1:0]    b_den_ff, b_den_in;

   // scaling stage
   logic                 c_valid_ff, c_zero_ff, c_wide_ff;
   logic [NUM_W-1:0]     c_num_ff, c_num_in;
   logic [PROD_W-1:0]    c_den_ff;

   // saturation compare (index 0) and division stages
   logic                 dv_valid_ff [0:DIV_STAGES];
   logic                 dv_zero_ff  [0:DIV_STAGES];
   logic                 dv_wide_ff  [0:DIV_STAGES];
   logic                 dv_sat_ff   [0:DIV_STAGES];
   logic [PROD_W-1:0]    dv_rem_ff   [0:DIV_STAGES];
   logic [PROD_W-1:0]    dv_den_ff   [0:DIV_STAGES];
   logic [QUO_W-1:0]     dv_low_ff   [0:DIV_STAGES];
   logic [QUO_W-1:0]     dv_quo_ff   [0:DIV_STAGES];
   logic                 sat_in;

   // rounding stage
   logic                 e_valid_ff, e_zero_ff, e_wide_ff, e_sat_ff;
   logic [QUO_W:0]       e_q_ff, e_q_in;
   logic [PROD_W:0]      twice_rem, den_ext;
   logic                 round_up;

   // output register
   logic                 rsp_valid_ff;
   logic                 out_wide_ff, out_zero_ff;
   logic [DEPTH_W-1:0]   rsp_disparity_ff, rsp_disparity_in;
   logic [QUO_W:0]       dmax_ext;

   assign adv       = rsp_ready || !rsp_valid_ff;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_disparity = rsp_disparity_ff;

   // configuration registers
   always_comb begin
      near_in = near_ff;
      far_in  = far_ff;
      wide_in = wide_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NEAR_DEPTH:  near_in = csr_wdata[DEPTH_W-1:0];
            CSR_FAR_DEPTH:   far_in  = csr_wdata[DEPTH_W-1:0];
            CSR_WIDE_OUTPUT: wide_in = csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= NEAR_RESET;
         far_ff  <= FAR_RESET;
         wide_ff <= 1'b0;
      end else begin
         near_ff <= near_in;
         far_ff  <= far_in;
         wide_ff <= wide_in;
      end
   end

   // entry: differences and the cases that give zero
   always_comb begin
      neg_num   = far_ff < req_depth_sample;
      neg_den   = far_ff < near_ff;
      a_dz_in   = neg_num ? req_depth_sample - far_ff : far_ff - req_depth_sample;
      a_dd_in   = neg_den ? near_ff - far_ff : far_ff - near_ff;
      a_zero_in = (req_depth_sample == '0) || (near_ff == far_ff) || (near_ff == '0)
                  || (a_dz_in == '0) || (neg_num != neg_den);
   end

   assign b_prod_in = a_zn_ff * a_dz_ff;
   assign b_den_in  = a_z_ff * a_dd_ff;

   // dmax * p as (p << k) - p
   assign c_num_in = b_wide_ff ? ({b_prod_ff, 16'b0} - {16'b0, b_prod_ff})
                               : ({8'b0, b_prod_ff, 8'b0} - {16'b0, b_prod_ff});

   assign sat_in = c_wide_ff ? (c_num_ff >= {c_den_ff, 16'b0})
                             : (c_num_ff >= {8'b0, c_den_ff, 8'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         b_valid_ff     <= 1'b0;
         c_valid_ff     <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         a_valid_ff     <= req_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         dv_valid_ff[0] <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_zero_ff <= a_zero_in;
         a_wide_ff <= wide_ff;
         a_zn_ff   <= near_ff;
         a_z_ff    <= req_depth_sample;
         a_dz_ff   <= a_dz_in;
         a_dd_ff   <= a_dd_in;

         b_zero_ff <= a_zero_ff;
         b_wide_ff <= a_wide_ff;
         b_prod_ff <= b_prod_in;
         b_den_ff  <= b_den_in;

         c_zero_ff <= b_zero_ff;
         c_wide_ff <= b_wide_ff;
         c_num_ff  <= c_num_in;
         c_den_ff  <= b_den_ff;

         dv_zero_ff[0] <= c_zero_ff;
         dv_wide_ff[0] <= c_wide_ff;
         dv_sat_ff[0]  <= sat_in;
         dv_rem_ff[0]  <= sat_in ? '0 : c_num_ff[NUM_W-1:QUO_W];
         dv_low_ff[0]  <= c_num_ff[QUO_W-1:0];
         dv_den_ff[0]  <= c_den_ff;
         dv_quo_ff[0]  <= '0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [PROD_W:0]   trial;
      logic              ge;
      logic [PROD_W-1:0] rem_in;

      always_comb begin
         trial  = {dv_rem_ff[k], dv_low_ff[k][QUO_W-1]};
         ge     = trial >= {1'b0, dv_den_ff[k]};
         rem_in = ge ? PROD_W'(trial - {1'b0, dv_den_ff[k]}) : trial[PROD_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_zero_ff[k+1] <= dv_zero_ff[k];
            dv_wide_ff[k+1] <= dv_wide_ff[k];
            dv_sat_ff[k+1]  <= dv_sat_ff[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            dv_rem_ff[k+1]  <= rem_in;
            dv_low_ff[k+1]  <= {dv_low_ff[k][QUO_W-2:0], 1'b0};
            dv_quo_ff[k+1]  <= {dv_quo_ff[k][QUO_W-2:0], ge};
         end
      end
   end

   // round to nearest, ties to even
   always_comb begin
      twice_rem = {dv_rem_ff[DIV_STAGES], 1'b0};
      den_ext   = {1'b0, dv_den_ff[DIV_STAGES]};
      round_up  = (twice_rem > den_ext)
                  || ((twice_rem == den_ext) && dv_quo_ff[DIV_STAGES][0]);
      e_q_in    = {1'b0, dv_quo_ff[DIV_STAGES]} + {{QUO_W{1'b0}}, round_up};
   end

   always_comb begin
      dmax_ext = e_wide_ff ? {1'b0, DMAX_WIDE} : {1'b0, DMAX_NARROW};
      if (e_zero_ff) begin
         rsp_disparity_in = '0;
      end else if (e_sat_ff || (e_q_ff > dmax_ext)) begin
         rsp_disparity_in = dmax_ext[DEPTH_W-1:0];
      end else begin
         rsp_disparity_in = e_q_ff[DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff   <= dv_valid_ff[DIV_STAGES];
         rsp_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_zero_ff        <= dv_zero_ff[DIV_STAGES];
         e_wide_ff        <= dv_wide_ff[DIV_STAGES];
         e_sat_ff         <= dv_sat_ff[DIV_STAGES];
         e_q_ff           <= e_q_in;
         out_wide_ff      <= e_wide_ff;
         out_zero_ff      <= e_zero_ff;
         rsp_disparity_ff <= rsp_disparity_in;
      end
   end

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[DIV_STAGES] && !dv_zero_ff[DIV_STAGES]
      |-> dv_rem_ff[DIV_STAGES] < dv_den_ff[DIV_STAGES])
      else $error("division remainder not below divisor");

   a_narrow_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_wide_ff |-> rsp_disparity <= DMAX_NARROW)
      else $error("narrow disparity above 255");

   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_zero_ff |-> rsp_disparity == '0)
      else $error("invalid depth gave non-zero disparity");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(e_q_ff) && (e_valid_ff == $past(e_valid_ff)))
      else $error("pipeline moved during stall");

endmodule
